// File: hdl/brlr_pkg.sv
package brlr_pkg;

  // command codes carried in the action field
  typedef enum logic [2:0] {
    ACT_STEP = 3'd0,
    ACT_LINE = 3'd1,
    ACT_HRUN = 3'd2,
    ACT_VRUN = 3'd3,
    ACT_RECT = 3'd4,
    ACT_FILL = 3'd5
  } brlr_action_e;

  localparam int ActionBits = 3;
  localparam int ColorBits  = 16;

  // configuration register indexes
  localparam int CfgIdxBits = 2;
  localparam logic [CfgIdxBits-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CfgIdxBits-1:0] CFG_SCREEN_HEIGHT = 2'd1;

  localparam int ScreenWidthReset  = 320;
  localparam int ScreenHeightReset = 240;

endpackage

// File: hdl/brlr_cmd_if.sv
interface brlr_cmd_if #(
  parameter int COORD_BITS = 12
);
  logic                         valid;
  logic                         ready;
  logic [2:0]                   action;
  logic signed [COORD_BITS-1:0] x_start;
  logic signed [COORD_BITS-1:0] y_start;
  logic signed [COORD_BITS-1:0] x_end;
  logic signed [COORD_BITS-1:0] y_end;
  logic signed [COORD_BITS-1:0] run_width;
  logic signed [COORD_BITS-1:0] run_height;
  logic [15:0]                  color;

  modport source (
    output valid, action, x_start, y_start, x_end, y_end, run_width, run_height, color,
    input  ready
  );
  modport sink (
    input  valid, action, x_start, y_start, x_end, y_end, run_width, run_height, color,
    output ready
  );
endinterface

// File: hdl/brlr_pix_if.sv
interface brlr_pix_if #(
  parameter int COORD_BITS = 12
);
  logic                       valid;
  logic                       ready;
  logic signed [COORD_BITS:0] pixel_x;
  logic signed [COORD_BITS:0] pixel_y;
  logic [15:0]                pixel_color;
  logic                       last_pixel;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, last_pixel,
    output ready
  );
endinterface

// File: hdl/brlr_cfg_if.sv
interface brlr_cfg_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            index;
  logic [COORD_BITS-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// File: hdl/brlr_setup.sv
module brlr_setup #(
  parameter int COORD_BITS = 12
) (
  input  brlr_pkg::brlr_action_e        action_i,
  input  logic signed [COORD_BITS-1:0]  x_start_i,
  input  logic signed [COORD_BITS-1:0]  y_start_i,
  input  logic signed [COORD_BITS-1:0]  x_end_i,
  input  logic signed [COORD_BITS-1:0]  y_end_i,
  input  logic signed [COORD_BITS-1:0]  run_width_i,
  input  logic signed [COORD_BITS-1:0]  run_height_i,
  input  logic [COORD_BITS-1:0]         screen_width_i,
  input  logic [COORD_BITS-1:0]         screen_height_i,
  // line setup
  output logic                          steep_o,
  output logic signed [COORD_BITS+1:0]  major_pos_o,
  output logic signed [COORD_BITS+1:0]  major_end_o,
  output logic signed [COORD_BITS+1:0]  minor_pos_o,
  output logic signed [COORD_BITS+1:0]  major_delta_o,
  output logic signed [COORD_BITS+1:0]  minor_delta_o,
  output logic signed [COORD_BITS+2:0]  error_o,
  output logic                          minor_down_o,
  // rectangle setup
  output logic                          rect_busy_o,
  output logic signed [COORD_BITS+1:0]  col_pos_o,
  output logic signed [COORD_BITS+1:0]  col_end_o,
  output logic signed [COORD_BITS+1:0]  col_top_o,
  output logic signed [COORD_BITS+1:0]  col_bot_o
);
  import brlr_pkg::*;

  localparam int W = COORD_BITS + 2;
  localparam int E = COORD_BITS + 3;

  logic signed [W-1:0] xs, ys, xe, ye, rw, rh;
  logic signed [W-1:0] x0, y0, x1, y1, dx, dy, adx, ady;
  logic signed [W-1:0] sx0, sy0, sx1, sy1;
  logic signed [W-1:0] ox0, oy0, ox1, oy1;
  logic signed [W-1:0] rx, ry, rwid, rhgt, rbot;

  assign xs = W'(x_start_i);
  assign ys = W'(y_start_i);
  assign xe = W'(x_end_i);
  assign ye = W'(y_end_i);
  assign rw = W'(run_width_i);
  assign rh = W'(run_height_i);

  // endpoints of the line form (runs are lines too)
  always_comb begin
    x0 = xs;
    y0 = ys;
    x1 = xe;
    y1 = ye;
    unique case (action_i)
      ACT_HRUN: begin
        x1 = xs + rw - W'(1);
        y1 = ys;
      end
      ACT_VRUN: begin
        x1 = xs;
        y1 = ys + rh - W'(1);
      end
      default: ;
    endcase
  end

  assign dx  = x1 - x0;
  assign dy  = y1 - y0;
  assign adx = dx[W-1] ? -dx : dx;
  assign ady = dy[W-1] ? -dy : dy;
  assign steep_o = ady > adx;

  // steep swap
  assign sx0 = steep_o ? y0 : x0;
  assign sy0 = steep_o ? x0 : y0;
  assign sx1 = steep_o ? y1 : x1;
  assign sy1 = steep_o ? x1 : y1;

  // walk the major axis upward
  always_comb begin
    if (sx0 > sx1) begin
      ox0 = sx1;
      oy0 = sy1;
      ox1 = sx0;
      oy1 = sy0;
    end else begin
      ox0 = sx0;
      oy0 = sy0;
      ox1 = sx1;
      oy1 = sy1;
    end
  end

  assign major_pos_o   = ox0;
  assign major_end_o   = ox1;
  assign minor_pos_o   = oy0;
  assign major_delta_o = ox1 - ox0;
  assign minor_delta_o = (oy1 < oy0) ? (oy0 - oy1) : (oy1 - oy0);
  assign error_o       = E'(major_delta_o >>> 1);
  assign minor_down_o  = !(oy0 < oy1);

  // rectangle or screen fill
  always_comb begin
    if (action_i == ACT_FILL) begin
      rx   = '0;
      ry   = '0;
      rwid = W'(screen_width_i);
      rhgt = W'(screen_height_i);
    end else begin
      rx   = xs;
      ry   = ys;
      rwid = rw;
      rhgt = rh;
    end
  end

  assign rbot        = ry + rhgt - W'(1);
  assign rect_busy_o = rwid > W'(0);
  assign col_pos_o   = rx;
  assign col_end_o   = rx + rwid - W'(1);
  assign col_top_o   = (ry < rbot) ? ry : rbot;
  assign col_bot_o   = (ry < rbot) ? rbot : ry;

endmodule

// File: hdl/bresenham_line_rect_rasterizer.sv
// a step beat while busy shows its pixel on pix_o in the cycle after it is accepted
// throughput: one command or step beat per cycle, one pixel per cycle, while pix_o keeps ready high
// the single output register frees cmd_i as soon as pix_o takes its beat
// load beats and steps while idle give no pixel; cfg_i takes a write every cycle
// reset (rst_ni low, async): idle, screen size 320 x 240, output register empty
module bresenham_line_rect_rasterizer #(
  parameter int COORD_BITS = 12
) (
  input logic         clk_i,
  input logic         rst_ni,
  brlr_cfg_if.sink    cfg_i,
  brlr_cmd_if.sink    cmd_i,
  brlr_pix_if.source  pix_o
);
  import brlr_pkg::*;

  // internal coordinate width covers start + length - 1 for any run
  localparam int W = COORD_BITS + 2;
  // error term needs one more bit for the subtract before the correction
  localparam int E = COORD_BITS + 3;

  localparam logic [COORD_BITS-1:0] ScrWReset = COORD_BITS'(ScreenWidthReset);
  localparam logic [COORD_BITS-1:0] ScrHReset = COORD_BITS'(ScreenHeightReset);

  // configuration registers
  logic [COORD_BITS-1:0] scr_w_q, scr_h_q;

  // drawing state
  logic                busy_q, busy_d;
  logic                steep_q, steep_d;
  logic                fill_q, fill_d;
  logic                minor_down_q, minor_down_d;
  logic signed [W-1:0] major_pos_q, major_pos_d;
  logic signed [W-1:0] major_end_q, major_end_d;
  logic signed [W-1:0] minor_pos_q, minor_pos_d;
  logic signed [W-1:0] major_delta_q, major_delta_d;
  logic signed [W-1:0] minor_delta_q, minor_delta_d;
  logic signed [E-1:0] err_q, err_d;
  logic signed [W-1:0] col_pos_q, col_pos_d;
  logic signed [W-1:0] col_end_q, col_end_d;
  logic signed [W-1:0] col_top_q, col_top_d;
  logic signed [W-1:0] col_bot_q, col_bot_d;
  logic [ColorBits-1:0] color_q, color_d;

  // output register
  logic                       out_valid_q, out_valid_d;
  logic signed [COORD_BITS:0] out_x_q, out_x_d;
  logic signed [COORD_BITS:0] out_y_q, out_y_d;
  logic [ColorBits-1:0]       out_color_q, out_color_d;
  logic                       out_last_q, out_last_d;

  // setup results for a load beat
  logic                su_steep, su_minor_down, su_rect_busy;
  logic signed [W-1:0] su_major_pos, su_major_end, su_minor_pos;
  logic signed [W-1:0] su_major_delta, su_minor_delta;
  logic signed [E-1:0] su_err;
  logic signed [W-1:0] su_col_pos, su_col_end, su_col_top, su_col_bot;

  brlr_action_e action;
  logic         cmd_beat;
  logic         pix_beat;

  // step datapath
  logic signed [W-1:0] px, py;
  logic                last;
  logic signed [E-1:0] err_sub;

  assign action   = brlr_action_e'(cmd_i.action);
  assign cmd_beat = cmd_i.valid && cmd_i.ready;
  assign pix_beat = pix_o.valid && pix_o.ready;

  // take a new beat whenever the output register is empty or draining now
  assign cmd_i.ready = !out_valid_q || pix_o.ready;
  assign cfg_i.ready = 1'b1;

  assign pix_o.valid       = out_valid_q;
  assign pix_o.pixel_x     = out_x_q;
  assign pix_o.pixel_y     = out_y_q;
  assign pix_o.pixel_color = out_color_q;
  assign pix_o.last_pixel  = out_last_q;

  brlr_setup #(
    .COORD_BITS (COORD_BITS)
  ) u_setup (
    .action_i        (action),
    .x_start_i       (cmd_i.x_start),
    .y_start_i       (cmd_i.y_start),
    .x_end_i         (cmd_i.x_end),
    .y_end_i         (cmd_i.y_end),
    .run_width_i     (cmd_i.run_width),
    .run_height_i    (cmd_i.run_height),
    .screen_width_i  (scr_w_q),
    .screen_height_i (scr_h_q),
    .steep_o         (su_steep),
    .major_pos_o     (su_major_pos),
    .major_end_o     (su_major_end),
    .minor_pos_o     (su_minor_pos),
    .major_delta_o   (su_major_delta),
    .minor_delta_o   (su_minor_delta),
    .error_o         (su_err),
    .minor_down_o    (su_minor_down),
    .rect_busy_o     (su_rect_busy),
    .col_pos_o       (su_col_pos),
    .col_end_o       (su_col_end),
    .col_top_o       (su_col_top),
    .col_bot_o       (su_col_bot)
  );

  // pixel of the current state and the error term after its major step
  assign err_sub = err_q - E'(minor_delta_q);

  always_comb begin
    if (fill_q) begin
      px   = col_pos_q;
      py   = major_pos_q;
      last = (major_pos_q == col_bot_q) && (col_pos_q == col_end_q);
    end else begin
      px   = steep_q ? minor_pos_q : major_pos_q;
      py   = steep_q ? major_pos_q : minor_pos_q;
      last = major_pos_q == major_end_q;
    end
  end

  always_comb begin
    busy_d        = busy_q;
    steep_d       = steep_q;
    fill_d        = fill_q;
    minor_down_d  = minor_down_q;
    major_pos_d   = major_pos_q;
    major_end_d   = major_end_q;
    minor_pos_d   = minor_pos_q;
    major_delta_d = major_delta_q;
    minor_delta_d = minor_delta_q;
    err_d         = err_q;
    col_pos_d     = col_pos_q;
    col_end_d     = col_end_q;
    col_top_d     = col_top_q;
    col_bot_d     = col_bot_q;
    color_d       = color_q;

    out_valid_d = out_valid_q && !pix_beat;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_color_d = out_color_q;
    out_last_d  = out_last_q;

    if (cmd_beat) begin
      unique case (action)
        ACT_LINE, ACT_HRUN, ACT_VRUN: begin
          color_d       = cmd_i.color;
          steep_d       = su_steep;
          major_pos_d   = su_major_pos;
          major_end_d   = su_major_end;
          minor_pos_d   = su_minor_pos;
          major_delta_d = su_major_delta;
          minor_delta_d = su_minor_delta;
          err_d         = su_err;
          minor_down_d  = su_minor_down;
          fill_d        = 1'b0;
          busy_d        = 1'b1;
        end
        ACT_RECT, ACT_FILL: begin
          // a rectangle of zero or negative width leaves the block idle
          color_d     = cmd_i.color;
          fill_d      = 1'b1;
          busy_d      = su_rect_busy;
          col_pos_d   = su_col_pos;
          col_end_d   = su_col_end;
          col_top_d   = su_col_top;
          col_bot_d   = su_col_bot;
          major_pos_d = su_col_top;
        end
        ACT_STEP: begin
          if (busy_q) begin
            out_valid_d = 1'b1;
            out_x_d     = px[COORD_BITS:0];
            out_y_d     = py[COORD_BITS:0];
            out_color_d = color_q;
            out_last_d  = last;
            if (fill_q) begin
              // down the column, then wrap to the top of the next one
              if (major_pos_q >= col_bot_q) begin
                major_pos_d = col_top_q;
                if (col_pos_q >= col_end_q) begin
                  busy_d = 1'b0;
                end else begin
                  col_pos_d = col_pos_q + W'(1);
                end
              end else begin
                major_pos_d = major_pos_q + W'(1);
              end
            end else begin
              err_d = err_sub;
              if (err_sub < 0) begin
                minor_pos_d = minor_down_q ? minor_pos_q - W'(1) : minor_pos_q + W'(1);
                err_d       = err_sub + E'(major_delta_q);
              end
              if (major_pos_q >= major_end_q) begin
                busy_d = 1'b0;
              end else begin
                major_pos_d = major_pos_q + W'(1);
              end
            end
          end
        end
        default: ;  // unused codes are dropped
      endcase
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q <= ScrWReset;
      scr_h_q <= ScrHReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        CFG_SCREEN_WIDTH:  scr_w_q <= cfg_i.data;
        CFG_SCREEN_HEIGHT: scr_h_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q        <= 1'b0;
      steep_q       <= 1'b0;
      fill_q        <= 1'b0;
      minor_down_q  <= 1'b0;
      major_pos_q   <= '0;
      major_end_q   <= '0;
      minor_pos_q   <= '0;
      major_delta_q <= '0;
      minor_delta_q <= '0;
      err_q         <= '0;
      col_pos_q     <= '0;
      col_end_q     <= '0;
      col_top_q     <= '0;
      col_bot_q     <= '0;
      color_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      busy_q        <= busy_d;
      steep_q       <= steep_d;
      fill_q        <= fill_d;
      minor_down_q  <= minor_down_d;
      major_pos_q   <= major_pos_d;
      major_end_q   <= major_end_d;
      minor_pos_q   <= minor_pos_d;
      major_delta_q <= major_delta_d;
      minor_delta_q <= minor_delta_d;
      err_q         <= err_d;
      col_pos_q     <= col_pos_d;
      col_end_q     <= col_end_d;
      col_top_q     <= col_top_d;
      col_bot_q     <= col_bot_d;
      color_q       <= color_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // output payload, no reset needed
  always_ff @(posedge clk_i) begin
    out_x_q     <= out_x_d;
    out_y_q     <= out_y_d;
    out_color_q <= out_color_d;
    out_last_q  <= out_last_d;
  end

endmodule
